### src/hexf_pkg.sv
// Shared types, character codes and helper functions for the ASCII-hex link framer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package hexf_pkg;

  localparam int FRAME_MAX   = 20;
  localparam int FRAME_LEN_W = $clog2(FRAME_MAX + 1);

  localparam logic [15:0] LIMIT_RESET = 16'd1000;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] OK_SUM   = 8'hF5;

  typedef enum logic [2:0] {
    CMD_READ    = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_RESET   = 3'd2,
    CMD_RX_BYTE = 3'd3,
    CMD_TIMEOUT = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_TX      = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_BAD_SUM    = 2'd2,
    ST_NACK       = 2'd3
  } status_t;

  typedef logic [FRAME_MAX-1:0][7:0] frame_t;

  // One result produced by the reply tracker
  typedef struct packed {
    logic       vld;
    kind_t      kind;
    logic [7:0] data;
    status_t    status;
  } res_t;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] w;
    w = {4'h0, n};
    return (n < 4'd10) ? (w + 8'h30) : (w + 8'h37);
  endfunction

  // Non-hex characters fold to (c - '0') mod 16
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] d;
    d = c - 8'h30;
    if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
    end
    return d[3:0];
  endfunction

  // Expected acknowledge: ':OK!' then the checksum byte
  function automatic logic [7:0] ok_char(input logic [2:0] i);
    logic [7:0] c;
    unique case (i)
      3'd0:    c = CH_COLON;
      3'd1:    c = CH_O;
      3'd2:    c = CH_K;
      3'd3:    c = CH_BANG;
      3'd4:    c = OK_SUM;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### src/hexf_frame_build.sv
// Request frame builder: turns a read, write or reset command into its transmit bytes.
// Depends on hexf_pkg for character codes, hex conversion and the frame type.
`timescale 1ns / 1ps

module hexf_frame_build (
  input  hexf_pkg::cmd_t                      cmd,
  input  logic [31:0]                         address,
  input  logic [15:0]                         length,
  input  logic [15:0]                         value,
  input  logic [15:0]                         limit,
  output hexf_pkg::frame_t                    frame,
  output logic [hexf_pkg::FRAME_LEN_W-1:0]    frame_len
);
  import hexf_pkg::*;

  frame_t      body;
  logic [15:0] clamped;
  logic [7:0]  psum [4];
  logic [7:0]  checksum;

  assign clamped = (value > limit) ? limit : value;

  always_comb begin
    body      = '0;
    frame_len = '0;
    body[0]   = CH_COLON;
    for (int i = 0; i < 8; i++) begin
      body[3+i] = hex_char(address[31-4*i -: 4]);
    end
    unique case (cmd)
      CMD_READ: begin
        body[1] = CH_R;
        body[2] = CH_D;
        for (int i = 0; i < 4; i++) begin
          body[11+i] = hex_char(length[15-4*i -: 4]);
        end
        frame_len = FRAME_LEN_W'(16);
      end
      CMD_WRITE: begin
        body[1]  = CH_W;
        body[2]  = CH_R;
        body[11] = CH_ZERO;
        body[12] = CH_ZERO;
        body[13] = CH_ZERO;
        body[14] = CH_TWO;
        for (int i = 0; i < 4; i++) begin
          body[15+i] = hex_char(clamped[15-4*i -: 4]);
        end
        frame_len = FRAME_LEN_W'(FRAME_MAX);
      end
      CMD_RESET: begin
        body = '0;
        body[0] = CH_COLON;
        body[1] = CH_HASH;
        body[2] = CH_HASH;
        frame_len = FRAME_LEN_W'(3);
      end
      default: begin
        frame_len = '0;
      end
    endcase
  end

  // Checksum over the body; unused positions are zero and add nothing
  always_comb begin
    for (int g = 0; g < 4; g++) begin
      psum[g] = 8'h00;
      for (int j = 0; j < 5; j++) begin
        psum[g] = psum[g] + body[5*g+j];
      end
    end
    checksum = (psum[0] + psum[1]) + (psum[2] + psum[3]);
  end

  always_comb begin
    frame = body;
    if (cmd == CMD_READ) begin
      frame[15] = checksum;
    end else if (cmd == CMD_WRITE) begin
      frame[19] = checksum;
    end
  end

endmodule

### src/hexf_rx_track.sv
// Reply tracker: counts and sums received bytes, decodes read payload, reports status.
// Depends on hexf_pkg for command, kind and status codes and the result struct.
`timescale 1ns / 1ps

module hexf_rx_track (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  hexf_pkg::cmd_t   cmd,
  input  logic [15:0]      length,
  input  logic [7:0]       rx_byte,
  output hexf_pkg::res_t   res
);
  import hexf_pkg::*;

  typedef enum logic [1:0] {
    WAIT_NONE  = 2'd0,
    WAIT_READ  = 2'd1,
    WAIT_WRITE = 2'd2,
    WAIT_RESET = 2'd3
  } wait_t;

  wait_t       wait_r,  wait_nxt;
  logic [17:0] cnt_r,   cnt_nxt;
  logic [7:0]  sum_r,   sum_nxt;
  logic [17:0] exp_r,   exp_nxt;
  logic [3:0]  hi_r,    hi_nxt;
  logic        ack_r,   ack_nxt;

  logic [18:0] cnt_p1;
  logic [17:0] cnt_inc;
  logic [3:0]  nib;

  assign cnt_p1  = {1'b0, cnt_r} + 19'd1;
  assign cnt_inc = cnt_p1[17:0];
  assign nib     = nibble_of(rx_byte);

  always_comb begin
    wait_nxt = wait_r;
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    exp_nxt  = exp_r;
    hi_nxt   = hi_r;
    ack_nxt  = ack_r;
    res      = '{vld: 1'b0, kind: KIND_STATUS, data: 8'h00, status: ST_OK};
    if (accept) begin
      unique case (cmd)
        CMD_READ, CMD_WRITE, CMD_RESET: begin
          wait_nxt = (cmd == CMD_READ)  ? WAIT_READ :
                     (cmd == CMD_WRITE) ? WAIT_WRITE : WAIT_RESET;
          exp_nxt  = (cmd == CMD_READ) ? (18'd4 + {1'b0, length, 1'b0}) : 18'd5;
          cnt_nxt  = '0;
          sum_nxt  = '0;
          hi_nxt   = '0;
          ack_nxt  = 1'b1;
        end
        CMD_RX_BYTE: begin
          if (wait_r == WAIT_READ) begin
            cnt_nxt = cnt_inc;
            if (cnt_p1 >= {1'b0, exp_r}) begin
              // last byte of the reply is its checksum
              res.vld    = 1'b1;
              res.status = (rx_byte == sum_r) ? ST_OK : ST_BAD_SUM;
              wait_nxt   = WAIT_NONE;
            end else begin
              sum_nxt = sum_r + rx_byte;
              if (cnt_r >= 18'd3) begin
                if (cnt_r[0]) begin
                  hi_nxt = nib;
                end else begin
                  res.vld  = 1'b1;
                  res.kind = KIND_PAYLOAD;
                  res.data = {hi_r, nib};
                end
              end
            end
          end else if (wait_r != WAIT_NONE) begin
            if (cnt_r < 18'd5 && rx_byte != ok_char(cnt_r[2:0])) begin
              ack_nxt = 1'b0;
            end
            sum_nxt = sum_r + rx_byte;
            cnt_nxt = cnt_inc;
            if (cnt_inc >= exp_r) begin
              res.vld    = 1'b1;
              res.status = ack_nxt ? ST_OK : ST_NACK;
              wait_nxt   = WAIT_NONE;
            end
          end
        end
        CMD_TIMEOUT: begin
          if (wait_r != WAIT_NONE) begin
            res.vld    = 1'b1;
            res.status = (wait_r == WAIT_READ) ? ST_INCOMPLETE : ST_NACK;
            wait_nxt   = WAIT_NONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r <= WAIT_NONE;
      cnt_r  <= '0;
      sum_r  <= '0;
      exp_r  <= '0;
      hi_r   <= '0;
      ack_r  <= 1'b1;
    end else begin
      wait_r <= wait_nxt;
      cnt_r  <= cnt_nxt;
      sum_r  <= sum_nxt;
      exp_r  <= exp_nxt;
      hi_r   <= hi_nxt;
      ack_r  <= ack_nxt;
    end
  end

endmodule

### src/hexf_out_queue.sv
// Result register and transmit shifter: holds a whole request frame or one single
// result and hands it out one transfer at a time. Depends on hexf_pkg.
`timescale 1ns / 1ps

module hexf_out_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  hexf_pkg::frame_t                  frame,
  input  logic [hexf_pkg::FRAME_LEN_W-1:0]  frame_len,
  input  hexf_pkg::res_t                    res,
  input  logic                              out_ready,
  output logic                              out_valid,
  output hexf_pkg::kind_t                   out_kind,
  output logic [7:0]                        out_data,
  output logic                              out_last,
  output hexf_pkg::status_t                 out_status,
  output logic                              room
);
  import hexf_pkg::*;

  logic [FRAME_LEN_W-1:0] rem_r, rem_nxt;
  frame_t                 buf_r, buf_nxt;
  kind_t                  kind_r, kind_nxt;
  status_t                status_r, status_nxt;
  logic                   take;

  assign out_valid  = (rem_r != '0);
  assign take       = out_valid && out_ready;
  assign room       = (rem_r == '0) || (rem_r == FRAME_LEN_W'(1) && out_ready);
  assign out_kind   = kind_r;
  assign out_status = status_r;
  assign out_data   = buf_r[0];
  assign out_last   = (kind_r == KIND_TX) && (rem_r == FRAME_LEN_W'(1));

  always_comb begin
    rem_nxt    = rem_r;
    buf_nxt    = buf_r;
    kind_nxt   = kind_r;
    status_nxt = status_r;
    priority if (accept && frame_len != '0) begin
      rem_nxt    = frame_len;
      buf_nxt    = frame;
      kind_nxt   = KIND_TX;
      status_nxt = ST_OK;
    end else if (accept && res.vld) begin
      rem_nxt    = FRAME_LEN_W'(1);
      buf_nxt[0] = res.data;
      kind_nxt   = res.kind;
      status_nxt = res.status;
    end else if (take) begin
      // advance to the next byte of the frame
      rem_nxt = rem_r - FRAME_LEN_W'(1);
      buf_nxt = {8'h00, buf_r[FRAME_MAX-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r    <= buf_nxt;
    kind_r   <= kind_nxt;
    status_r <= status_nxt;
  end

endmodule

### src/hex_ascii_ecu_link_framer_unit.sv
// Top level of the ASCII-hex engine controller link framer.
// Instantiates hexf_frame_build, hexf_rx_track and hexf_out_queue; uses hexf_pkg.
//
// Usage:
//   in_*  : commands (read, write, reset request, received byte, timeout).
//           in_tuser carries the command code, in_tdata the operands.
//   out_* : results. out_tuser gives the kind (transmit byte, decoded payload
//           byte, status); out_tlast marks the final byte of a request frame.
//   cfg_* : write of the write-value clamp; always ready, reset value 1000.
// The first result of an item is registered, valid the cycle after its transfer.
// A received byte, timeout or ignored command is taken every cycle while
//   results drain without stall. A request frame of 3, 16 or 20 bytes leaves
//   one byte per cycle from the transmit shifter while the receiver does not
//   stall; in_tready drops until the frame is down to its last byte.
// Reset (rst_n low, synchronous) clears the reply tracker to idle with nothing
//   pending and empties the result register.
// When the receiver stalls, the current result holds on out_* and in_tready
//   stays low until the last pending result is being taken.
`timescale 1ns / 1ps

module hex_ascii_ecu_link_framer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // address[31:0], length[47:32], value[63:48], rx_byte[71:64]
  input  logic [2:0]  in_tuser,   // command[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // data[7:0], status[9:8], zero[15:10]
  output logic [1:0]  out_tuser,  // kind[1:0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import hexf_pkg::*;

  logic                   accept;
  cmd_t                   cmd;
  logic [31:0]            address;
  logic [15:0]            length;
  logic [15:0]            value;
  logic [7:0]             rx_byte;
  logic [15:0]            limit_r;
  frame_t                 frame;
  logic [FRAME_LEN_W-1:0] frame_len;
  res_t                   res;
  kind_t                  out_kind;
  status_t                out_status;
  logic [7:0]             out_data;

  assign cmd       = cmd_t'(in_tuser);
  assign address   = in_tdata[31:0];
  assign length    = in_tdata[47:32];
  assign value     = in_tdata[63:48];
  assign rx_byte   = in_tdata[71:64];
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  hexf_frame_build u_build (
    .cmd       (cmd),
    .address   (address),
    .length    (length),
    .value     (value),
    .limit     (limit_r),
    .frame     (frame),
    .frame_len (frame_len)
  );

  hexf_rx_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .cmd     (cmd),
    .length  (length),
    .rx_byte (rx_byte),
    .res     (res)
  );

  hexf_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .frame      (frame),
    .frame_len  (frame_len),
    .res        (res),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_kind   (out_kind),
    .out_data   (out_data),
    .out_last   (out_tlast),
    .out_status (out_status),
    .room       (in_tready)
  );

  assign out_tuser = out_kind;
  assign out_tdata = {6'b000000, out_status, out_data};

endmodule

### src/hexf_checker.sv
// Port-level checker for the link framer, bound to the top level.
// Depends on hexf_pkg for the result kind and status codes.
`timescale 1ns / 1ps

module hexf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import hexf_pkg::*;

  // only transmit bytes close a frame
  a_last_is_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == KIND_TX)
    else $error("frame end flagged on a non-transmit result");

  a_status_only_in_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_STATUS |-> out_tdata[9:8] == ST_OK)
    else $error("status bits set on a data result");

  a_status_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_STATUS |-> out_tdata[7:0] == 8'h00)
    else $error("status result carries data");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind hex_ascii_ecu_link_framer_unit hexf_checker u_hexf_checker (.*);

### sim/tb_top.sv
// Self-checking testbench for hex_ascii_ecu_link_framer_unit: request frames, reply decoding,
// clamp register and transaction status. Depends on hexf_pkg and the framer RTL.
`timescale 1ns / 1ps

module tb_top;
  import hexf_pkg::*;

  localparam logic [2:0]  CMD_SPARE_LAST   = 3'd7;
  localparam logic [15:0] WRITE_WORD_COUNT = 16'd2;
  localparam int          LONG_GAP_MAX     = 40;
  localparam int          SETTLE_CYCLES    = 8;

  // how a generated transaction ends
  localparam int FATE_CLEAN   = 0;
  localparam int FATE_BAD_SUM = 1;
  localparam int FATE_TIMEOUT = 2;
  localparam int FATE_CUT     = 3;

  typedef enum logic [1:0] {PEND_NONE, PEND_READ, PEND_WRITE, PEND_RESET} pend_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] addr;
    logic [15:0] len;
    logic [15:0] val;
    logic [7:0]  rx;
  } link_cmd_t;

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
    status_t    status;
  } link_res_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata   = '0;  // address[31:0], length[47:32], value[63:48], rx_byte[71:64]
  logic [2:0]  in_tuser   = '0;  // command[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // data[7:0], status[9:8], zero[15:10]
  logic [1:0]  out_tuser;        // kind[1:0]
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data   = '0;

  hex_ascii_ecu_link_framer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  link_cmd_t   cmd_queue[$];
  link_res_t   link_results_due[$];
  link_cmd_t   cmd_on_bus;
  link_res_t   oldest_due;
  logic        in_xfer  = 1'b0;
  logic        cfg_xfer = 1'b0;
  int          in_gap   = 0;
  int          out_stall = 0;
  bit          no_idle  = 1'b0;
  logic [15:0] limit_now = LIMIT_RESET;
  int          live_count = 0;
  int          fail_count = 0;
  int          cmds_taken = 0;
  int          results_checked = 0;
  int          status_seen = 0;

  // Predictor state: clamp register and reply tracker
  logic [15:0] clamp_limit = LIMIT_RESET;
  pend_t       pend        = PEND_NONE;
  logic [17:0] rcv_count   = '0;
  logic [17:0] reply_len   = '0;
  logic [7:0]  rcv_sum     = '0;
  logic [3:0]  hi_nib      = '0;
  logic        ack_ok      = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] ascii_hex(input logic [3:0] n);
    return (n < 4'd10) ? {4'h0, n} + CH_ZERO : {4'h0, n} - 8'd10 + "A";
  endfunction

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    if (c >= "A" && c <= "F") begin
      d = c - "A" + 8'd10;
    end else if (c >= "a" && c <= "f") begin
      d = c - "a" + 8'd10;
    end else begin
      d = c - "0";
    end
    return d[3:0];
  endfunction

  function automatic logic [7:0] ack_byte(input int i);
    case (i)
      0:       return CH_COLON;
      1:       return CH_O;
      2:       return CH_K;
      3:       return CH_BANG;
      default: return OK_SUM;
    endcase
  endfunction

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, LONG_GAP_MAX);
  endfunction

  task automatic push_result(input kind_t k, input logic [7:0] d, input logic l,
                             input status_t s);
    link_res_t r;
    r.kind   = k;
    r.data   = d;
    r.last   = l;
    r.status = s;
    link_results_due.push_back(r);
  endtask

  task automatic start_reply(input pend_t what, input logic [17:0] bytes);
    pend      = what;
    reply_len = bytes;
    rcv_count = '0;
    rcv_sum   = '0;
    hi_nib    = '0;
    ack_ok    = 1'b1;
  endtask

  // Work out the results one accepted command causes and advance the tracker
  task automatic frame_and_track(input link_cmd_t c);
    logic [7:0]  frame [FRAME_MAX];
    int          flen;
    logic [7:0]  sum;
    logic [15:0] wval;
    status_t     st;
    flen = 0;
    case (c.cmd)
      CMD_READ, CMD_WRITE: begin
        frame[0] = CH_COLON;
        frame[1] = (c.cmd == CMD_READ) ? CH_R : CH_W;
        frame[2] = (c.cmd == CMD_READ) ? CH_D : CH_R;
        for (int i = 0; i < 8; i++) frame[3 + i] = ascii_hex(c.addr[31 - 4 * i -: 4]);
        wval = (c.val > clamp_limit) ? clamp_limit : c.val;
        if (c.cmd == CMD_READ) begin
          for (int i = 0; i < 4; i++) frame[11 + i] = ascii_hex(c.len[15 - 4 * i -: 4]);
          flen = 15;
          start_reply(PEND_READ, 18'd4 + {1'b0, c.len, 1'b0});
        end else begin
          for (int i = 0; i < 4; i++) begin
            frame[11 + i] = ascii_hex(WRITE_WORD_COUNT[15 - 4 * i -: 4]);
            frame[15 + i] = ascii_hex(wval[15 - 4 * i -: 4]);
          end
          flen = 19;
          start_reply(PEND_WRITE, 18'd5);
        end
        sum = '0;
        for (int i = 0; i < flen; i++) sum += frame[i];
        frame[flen] = sum;
        flen++;
      end
      CMD_RESET: begin
        frame[0] = CH_COLON;
        frame[1] = CH_HASH;
        frame[2] = CH_HASH;
        flen = 3;
        start_reply(PEND_RESET, 18'd5);
      end
      CMD_RX_BYTE: begin
        if (pend == PEND_READ) begin
          if ({1'b0, rcv_count} + 19'd1 >= {1'b0, reply_len}) begin
            // checksum position: compare with the running sum, then go idle
            if (c.rx == rcv_sum) st = ST_OK;
            else st = ST_BAD_SUM;
            push_result(KIND_STATUS, 8'h00, 1'b0, st);
            pend = PEND_NONE;
          end else begin
            rcv_sum += c.rx;
            if (rcv_count >= 18'd3) begin
              // odd count is the first digit of a pair
              if (rcv_count[0]) hi_nib = digit_value(c.rx);
              else push_result(KIND_PAYLOAD, {hi_nib, digit_value(c.rx)}, 1'b0, ST_OK);
            end
          end
          rcv_count = rcv_count + 18'd1;
        end else if (pend != PEND_NONE) begin
          if (rcv_count < 18'd5 && c.rx != ack_byte(int'(rcv_count))) ack_ok = 1'b0;
          rcv_sum   += c.rx;
          rcv_count = rcv_count + 18'd1;
          if (rcv_count >= reply_len) begin
            if (ack_ok) st = ST_OK;
            else st = ST_NACK;
            push_result(KIND_STATUS, 8'h00, 1'b0, st);
            pend = PEND_NONE;
          end
        end
      end
      CMD_TIMEOUT: begin
        if (pend != PEND_NONE) begin
          if (pend == PEND_READ) st = ST_INCOMPLETE;
          else st = ST_NACK;
          push_result(KIND_STATUS, 8'h00, 1'b0, st);
          pend = PEND_NONE;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < flen; i++) push_result(KIND_TX, frame[i], i == flen - 1, ST_OK);
  endtask

  // Sample transfers, check results, track configuration and predict
  always @(posedge clk) begin
    in_xfer  <= rst_n && in_tvalid && in_tready;
    cfg_xfer <= rst_n && cfg_valid && cfg_ready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_checked++;
        if (link_results_due.size() == 0) begin
          $error("unexpected result: kind %0d data %02h status %0d last %0b",
                 out_tuser, out_tdata[7:0], out_tdata[9:8], out_tlast);
          fail_count++;
        end else begin
          oldest_due = link_results_due.pop_front();
          if (oldest_due.kind == KIND_STATUS) status_seen++;
          if (out_tuser !== oldest_due.kind) begin
            $error("kind: expected %0d, actual %0d", oldest_due.kind, out_tuser);
            fail_count++;
          end
          if (out_tdata[7:0] !== oldest_due.data) begin
            $error("data: expected %02h, actual %02h", oldest_due.data, out_tdata[7:0]);
            fail_count++;
          end
          if (out_tdata[9:8] !== oldest_due.status) begin
            $error("status: expected %0d, actual %0d", oldest_due.status, out_tdata[9:8]);
            fail_count++;
          end
          if (out_tlast !== oldest_due.last) begin
            $error("frame_last: expected %0b, actual %0b", oldest_due.last, out_tlast);
            fail_count++;
          end
          if (out_tdata[15:10] !== 6'd0) begin
            $error("tdata pad: expected 0, actual %0h", out_tdata[15:10]);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) clamp_limit = cfg_data;
      if (in_tvalid && in_tready) begin
        frame_and_track(cmd_on_bus);
        cmds_taken++;
      end
    end
  end

  // Command driver: hold until transfer, then idle a while or load the next one
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_xfer) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap--;
      end else if (cmd_queue.size() > 0) begin
        cmd_on_bus = cmd_queue.pop_front();
        in_tdata  <= {cmd_on_bus.rx, cmd_on_bus.val, cmd_on_bus.len, cmd_on_bus.addr};
        in_tuser  <= cmd_on_bus.cmd;
        in_tvalid <= 1'b1;
        in_gap = no_idle ? 0 : idle_length();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver with random stalls
  always @(negedge clk) begin
    if (no_idle || out_stall == 0) begin
      out_tready <= 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0) out_stall = idle_length();
    end else begin
      out_tready <= 1'b0;
      out_stall--;
    end
  end

  task automatic queue_cmd(input logic [2:0] cmd, input logic [31:0] addr,
                           input logic [15:0] len, input logic [15:0] val,
                           input logic [7:0] rx, input bit live);
    link_cmd_t c;
    c.cmd  = cmd;
    c.addr = addr;
    c.len  = len;
    c.val  = val;
    c.rx   = rx;
    cmd_queue.push_back(c);
    if (live) live_count++;
  endtask

  task automatic queue_rx(input logic [7:0] b, input bit live);
    queue_cmd(CMD_RX_BYTE, $urandom, 16'($urandom), 16'($urandom), b, live);
  endtask

  task automatic queue_timeout(input bit live);
    queue_cmd(CMD_TIMEOUT, $urandom, 16'($urandom), 16'($urandom), 8'($urandom), live);
  endtask

  function automatic logic [7:0] reply_digit();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return ascii_hex(4'($urandom));
    if (r < 8) return "a" + 8'($urandom_range(0, 5));
    return 8'($urandom);
  endfunction

  // Read request plus its reply; long reads are only ever cut short
  task automatic queue_read_txn(input logic [31:0] addr, input logic [15:0] len,
                                input int fate);
    logic [7:0] reply[$];
    logic [7:0] sum;
    int         body;
    int         cut;
    int         bit_pos;
    queue_cmd(CMD_READ, addr, len, 16'($urandom), 8'($urandom), 1'b1);
    body = (len > 16'd8) ? 12 : 2 + 2 * len;
    reply.push_back(CH_COLON);
    for (int i = 0; i < body; i++) reply.push_back(reply_digit());
    if (len <= 16'd8) begin
      sum = '0;
      foreach (reply[i]) sum += reply[i];
      if (fate == FATE_BAD_SUM) begin
        bit_pos = $urandom_range(0, 7);
        sum[bit_pos] = ~sum[bit_pos];
      end
      reply.push_back(sum);
    end
    cut = reply.size();
    if (fate == FATE_TIMEOUT || fate == FATE_CUT) cut = $urandom_range(0, reply.size() - 1);
    for (int i = 0; i < cut; i++) queue_rx(reply[i], 1'b1);
    if (fate == FATE_TIMEOUT) queue_timeout(1'b1);
  endtask

  // Write or reset request plus its acknowledge
  task automatic queue_ack_txn(input logic [2:0] cmd, input int fate);
    logic [7:0]  ack [5];
    logic [15:0] v;
    int          cut;
    int          idx;
    int          bit_pos;
    case ($urandom_range(0, 4))
      0:       v = limit_now;
      1:       v = limit_now + 16'd1;
      2:       v = limit_now - 16'd1;
      default: v = 16'($urandom);
    endcase
    queue_cmd(cmd, $urandom, 16'($urandom), v, 8'($urandom), 1'b1);
    for (int i = 0; i < 5; i++) ack[i] = ack_byte(i);
    if (fate == FATE_BAD_SUM) begin
      idx = $urandom_range(0, 4);
      bit_pos = $urandom_range(0, 7);
      ack[idx][bit_pos] = ~ack[idx][bit_pos];
    end
    cut = (fate == FATE_TIMEOUT || fate == FATE_CUT) ? $urandom_range(0, 4) : 5;
    for (int i = 0; i < cut; i++) queue_rx(ack[i], 1'b1);
    if (fate == FATE_TIMEOUT) begin
      queue_timeout(1'b1);
    end else if (fate == FATE_CLEAN && $urandom_range(0, 3) == 0) begin
      queue_rx(8'($urandom), 1'b0);  // stray byte after the reply is done
    end
  endtask

  task automatic queue_random_traffic(input int goal);
    int first;
    int pick;
    int fate;
    first = live_count;
    while (live_count - first < goal) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: fate = FATE_CLEAN;
        6:                fate = FATE_BAD_SUM;
        7, 8:             fate = FATE_TIMEOUT;
        default:          fate = FATE_CUT;
      endcase
      if (pick < 4) begin
        queue_read_txn($urandom, 16'($urandom_range(9, 65535)), FATE_TIMEOUT);
      end else if (pick < 45) begin
        queue_read_txn($urandom, 16'(($urandom_range(0, 3) == 0) ?
                       $urandom_range(4, 8) : $urandom_range(0, 3)), fate);
      end else if (pick < 68) begin
        queue_ack_txn(CMD_WRITE, fate);
      end else if (pick < 85) begin
        queue_ack_txn(CMD_RESET, fate);
      end else begin
        queue_cmd(3'($urandom_range(CMD_RX_BYTE, CMD_SPARE_LAST)), $urandom,
                  16'($urandom), 16'($urandom), 8'($urandom), 1'b0);
      end
    end
  endtask

  // Wait for the driver and the result queue to drain, then let the block settle
  task automatic wait_idle();
    do @(posedge clk);
    while (cmd_queue.size() != 0 || in_tvalid || link_results_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    limit_now = v;
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(negedge clk);
    while (!cfg_xfer) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [15:0] limit_plan [6];
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: idle noise, extreme fields, every command, each reply outcome
    queue_timeout(1'b0);
    queue_rx(8'h00, 1'b0);
    queue_cmd(CMD_SPARE_LAST, '1, '1, '1, '1, 1'b0);
    queue_read_txn(32'h0000_0000, 16'h0000, FATE_CLEAN);
    queue_cmd(CMD_READ, 32'hFFFF_FFFF, 16'd1, 16'h0000, 8'hFF, 1'b1);
    queue_rx(CH_COLON, 1'b1);
    queue_rx("0", 1'b1);
    queue_rx("1", 1'b1);
    queue_rx("f", 1'b1);   // lowercase digit
    queue_rx("G", 1'b1);   // not a hex digit
    queue_rx(8'h49, 1'b1); // true sum is 0x48
    queue_cmd(CMD_WRITE, 32'h89AB_CDEF, 16'h0000, 16'hFFFF, 8'h00, 1'b1);  // clamped
    queue_ack_txn(CMD_RESET, FATE_CLEAN);  // drops the pending write
    queue_cmd(CMD_WRITE, 32'h0123_4567, 16'hFFFF, 16'h0000, 8'h00, 1'b1);
    queue_timeout(1'b1);
    queue_cmd(CMD_READ, 32'h5A5A_A5A5, 16'hFFFF, 16'hFFFF, 8'h00, 1'b1);
    queue_timeout(1'b1);
    wait_idle();

    limit_plan[0] = 16'h0000;
    limit_plan[1] = 16'hFFFF;
    limit_plan[2] = 16'($urandom);
    limit_plan[3] = LIMIT_RESET;
    limit_plan[4] = 16'd1;
    limit_plan[5] = 16'($urandom_range(0, 2000));
    foreach (limit_plan[p]) begin
      write_limit(limit_plan[p]);
      no_idle = (p == 3);
      queue_random_traffic(55);
      wait_idle();
    end

    $display("Ran %0d commands through six clamp settings (0 and 65535 included);",
             cmds_taken);
    $display("checked %0d results, %0d of them transaction statuses.",
             results_checked, status_seen);
    if (fail_count == 0) begin
      $display("hex_ascii_ecu_link_framer_unit: match");
    end else begin
      $display("hex_ascii_ecu_link_framer_unit: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #(50_000_000);
    $display("hex_ascii_ecu_link_framer_unit: mismatch");
    $finish;
  end

endmodule

### sim.f
src/hexf_pkg.sv
src/hexf_frame_build.sv
src/hexf_rx_track.sv
src/hexf_out_queue.sv
src/hex_ascii_ecu_link_framer_unit.sv
src/hexf_checker.sv
sim/tb_top.sv
